// ===== rtl/scba_pkg.sv =====
// Package of the size class block allocator: shared widths, codes and the class size table.
`timescale 1ns / 1ps

package scba_pkg;

  localparam int unsigned NUM_CLASSES     = 33;
  localparam int unsigned CLS_W           = 6;
  localparam int unsigned SIZE_W          = 32;
  localparam int unsigned ADDR_W          = 19;
  localparam int unsigned IDX_W           = 17;      // block index = address / 4
  localparam int unsigned HEAD_W          = 18;      // index plus empty marker
  localparam int unsigned CNT_W           = 18;
  localparam int unsigned BLK_W           = 13;      // largest block is 4096 bytes
  localparam int unsigned MAX_CLASS_BYTES = 4096;

  localparam logic [HEAD_W-1:0] EMPTY_MARK = HEAD_W'(18'h20000);
  localparam logic [CNT_W-1:0]  COUNT_MAX  = CNT_W'(18'h20000);

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // defaults of the top level parameters
  localparam int unsigned PAGE_BYTES_DEF         = 8192;
  localparam int unsigned POOL_PAGES_DEF         = 64;
  localparam int unsigned ALIGN_BYTES_DEF        = 4;
  localparam int unsigned BLOCK_HEADER_BYTES_DEF = 4;
  localparam int unsigned PAGE_HEADER_BYTES_DEF  = 4;

  localparam int unsigned CLASS_BYTES [NUM_CLASSES] = '{
    4, 8, 12, 16, 24, 32, 40, 48, 64, 80, 96, 112,
    128, 160, 192, 224, 256, 320, 384, 448, 512, 640, 768, 896,
    1024, 1280, 1536, 1792, 2048, 2560, 3072, 3584, 4096
  };

endpackage

// ===== rtl/size_class_block_allocator.sv =====
// Size class block allocator: per class LIFO free lists with lazy page carving.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | input     | in_valid_i / in_stall_o  | kind, request_size, block_address
//  out     | output    | out_valid_o / out_stall_i| granted_address, size_class, to_heap,
//          |           |                         | out_of_pages, class_free_blocks
//
// Releases, heap sizes and carved allocations pass through S_IDLE and S_CLASS; an allocation
// from a free list adds S_LINK, as the link memory is read after the class entry read.
// The class entry is read at the transfer in, the link in S_CLASS; a new transfer waits for S_IDLE.
// Reset clears the class valid bits and the page counter; the link memory is not cleared.
// A result waiting on a stalled output does not stop the next transfer in; that item
// holds its last cycle, with no state written, until the output register is free.
`timescale 1ns / 1ps

module size_class_block_allocator #(
  parameter int unsigned PAGE_BYTES         = scba_pkg::PAGE_BYTES_DEF,
  parameter int unsigned POOL_PAGES         = scba_pkg::POOL_PAGES_DEF,
  parameter int unsigned ALIGN_BYTES        = scba_pkg::ALIGN_BYTES_DEF,
  parameter int unsigned BLOCK_HEADER_BYTES = scba_pkg::BLOCK_HEADER_BYTES_DEF,
  parameter int unsigned PAGE_HEADER_BYTES  = scba_pkg::PAGE_HEADER_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [scba_pkg::SIZE_W-1:0]  request_size_i,
  input  logic [scba_pkg::ADDR_W-1:0]  block_address_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [scba_pkg::ADDR_W-1:0]  granted_address_o,
  output logic [scba_pkg::CLS_W-1:0]   size_class_o,
  output logic                         to_heap_o,
  output logic                         out_of_pages_o,
  output logic [scba_pkg::CNT_W-1:0]   class_free_blocks_o
);
  import scba_pkg::*;

  // smallest block belongs to class 0 and sets the carve counter width
  localparam int unsigned Blk0Raw  = (CLASS_BYTES[0] < BLOCK_HEADER_BYTES) ?
                                     BLOCK_HEADER_BYTES : CLASS_BYTES[0];
  localparam int unsigned Blk0     = ((Blk0Raw + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int unsigned MaxPerPg = (PAGE_BYTES - PAGE_HEADER_BYTES) / Blk0;
  localparam int unsigned CL_W     = (MaxPerPg < 1) ? 1 : $clog2(MaxPerPg + 1);
  localparam int unsigned PU_W     = $clog2(POOL_PAGES + 1);
  localparam int unsigned LinkDepth = 2 ** IDX_W;

  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [ADDR_W-1:0] cnext;
    logic [CL_W-1:0]   cleft;
    logic [CNT_W-1:0]  fcount;
  } cls_ent_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLASS,
    S_LINK
  } state_e;

  localparam cls_ent_t ENT_RESET = '{head: EMPTY_MARK, cnext: '0, cleft: '0, fcount: '0};

  // per class block geometry, worked out at elaboration
  logic [BLK_W-1:0] blk_tbl [NUM_CLASSES];
  logic [CL_W-1:0]  pp_tbl  [NUM_CLASSES];

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_geom
    localparam int unsigned Raw  = (CLASS_BYTES[g] < BLOCK_HEADER_BYTES) ?
                                   BLOCK_HEADER_BYTES : CLASS_BYTES[g];
    localparam int unsigned Blk  = ((Raw + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int unsigned PerP = (PAGE_BYTES - PAGE_HEADER_BYTES) / Blk;
    assign blk_tbl[g] = BLK_W'(Blk);
    assign pp_tbl[g]  = CL_W'(PerP);
  end

  state_e             state_q;
  logic               req_kind_q;
  logic               req_heap_q;
  logic [CLS_W-1:0]   req_cls_q;
  logic [IDX_W-1:0]   req_idx_q;
  logic [NUM_CLASSES-1:0] cvld_q;
  logic               cls_rd_vld_q;
  cls_ent_t           cls_rd_q;
  logic [HEAD_W-1:0]  link_rd_q;
  logic [PU_W-1:0]    pages_q;
  logic [ADDR_W-1:0]  page_base_q;

  logic               out_valid_q;
  logic [ADDR_W-1:0]  granted_q;
  logic [CLS_W-1:0]   cls_out_q;
  logic               heap_q;
  logic               oop_q;
  logic [CNT_W-1:0]   fc_out_q;

  cls_ent_t           cls_mem  [NUM_CLASSES];
  logic [HEAD_W-1:0]  link_mem [LinkDepth];

  logic               accept;
  logic               out_free;
  logic [CLS_W-1:0]   cls_in;
  cls_ent_t           ent;
  cls_ent_t           new_ent;
  logic               finish;
  logic               go_link;
  logic               cmem_we;
  logic               link_we;
  logic               page_take;
  logic [ADDR_W-1:0]  res_granted;
  logic               res_heap;
  logic               res_oop;
  logic [CNT_W-1:0]   res_fc;
  logic [BLK_W-1:0]   blk;
  logic [CL_W-1:0]    per_page;
  logic [CNT_W:0]     fc_sum;
  logic [ADDR_W-1:0]  carve_addr;
  logic [CL_W-1:0]    carve_left;
  logic [CNT_W-1:0]   carve_fc;
  logic               carve_ok;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // smallest class that holds the size; sizes above the table end in the last class
  always_comb begin
    cls_in = CLS_W'(NUM_CLASSES - 1);
    for (int c = NUM_CLASSES - 2; c >= 0; c--) begin
      if (request_size_i <= SIZE_W'(CLASS_BYTES[c])) cls_in = CLS_W'(c);
    end
  end

  assign ent      = cls_rd_vld_q ? cls_rd_q : ENT_RESET;
  assign blk      = blk_tbl[req_cls_q];
  assign per_page = pp_tbl[req_cls_q];

  always_comb begin
    finish      = 1'b0;
    go_link     = 1'b0;
    cmem_we     = 1'b0;
    link_we     = 1'b0;
    page_take   = 1'b0;
    new_ent     = ent;
    res_granted = '0;
    res_heap    = 1'b0;
    res_oop     = 1'b0;
    res_fc      = '0;
    fc_sum      = '0;
    carve_addr  = ent.cnext;
    carve_left  = ent.cleft;
    carve_fc    = ent.fcount;
    carve_ok    = 1'b1;
    case (state_q)
      S_CLASS: begin
        if (req_heap_q) begin
          res_heap = 1'b1;
          finish   = out_free;
        end else if (req_kind_q == KIND_RELEASE) begin
          new_ent.head = {1'b0, req_idx_q};
          if (ent.fcount < COUNT_MAX) new_ent.fcount = ent.fcount + CNT_W'(1);
          res_fc  = new_ent.fcount;
          link_we = out_free;
          cmem_we = out_free;
          finish  = out_free;
        end else if (ent.head != EMPTY_MARK) begin
          go_link = 1'b1;
        end else begin
          if (ent.cleft == '0) begin
            if ((pages_q >= PU_W'(POOL_PAGES)) || (per_page == '0)) begin
              carve_ok = 1'b0;
            end else begin
              carve_addr = page_base_q;
              carve_left = per_page;
              fc_sum     = {1'b0, ent.fcount} + (CNT_W + 1)'(per_page);
              carve_fc   = (fc_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : fc_sum[CNT_W-1:0];
              page_take  = out_free;
            end
          end
          if (carve_ok) begin
            res_granted   = carve_addr;
            new_ent.cnext = carve_addr + ADDR_W'(blk);
            new_ent.cleft = carve_left - CL_W'(1);
            new_ent.fcount = (carve_fc != '0) ? carve_fc - CNT_W'(1) : carve_fc;
            cmem_we       = out_free;
          end else begin
            res_oop = 1'b1;
          end
          res_fc = carve_ok ? new_ent.fcount : ent.fcount;
          finish = out_free;
        end
      end
      S_LINK: begin
        res_granted  = {ent.head[IDX_W-1:0], 2'b00};
        new_ent.head = (link_rd_q > EMPTY_MARK) ? EMPTY_MARK : link_rd_q;
        if (ent.fcount != '0) new_ent.fcount = ent.fcount - CNT_W'(1);
        res_fc  = new_ent.fcount;
        cmem_we = out_free;
        finish  = out_free;
      end
      default: begin
      end
    endcase
  end

  // class memory: read at the transfer in, written back at the end of the item
  always_ff @(posedge clk_i) begin
    if (cmem_we) cls_mem[req_cls_q] <= new_ent;
    if (accept) cls_rd_q <= cls_mem[cls_in];
  end

  // link memory: written by releases, read when a list is popped
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[req_idx_q] <= ent.head;
    if (go_link) link_rd_q <= link_mem[ent.head[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      req_kind_q   <= KIND_ALLOC;
      req_heap_q   <= 1'b0;
      req_cls_q    <= '0;
      req_idx_q    <= '0;
      cvld_q       <= '0;
      cls_rd_vld_q <= 1'b0;
      pages_q      <= '0;
      page_base_q  <= ADDR_W'(PAGE_HEADER_BYTES);
      out_valid_q  <= 1'b0;
      granted_q    <= '0;
      cls_out_q    <= '0;
      heap_q       <= 1'b0;
      oop_q        <= 1'b0;
      fc_out_q     <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !finish) out_valid_q <= 1'b0;
      if (cmem_we) cvld_q[req_cls_q] <= 1'b1;
      if (page_take) begin
        pages_q     <= pages_q + PU_W'(1);
        page_base_q <= page_base_q + ADDR_W'(PAGE_BYTES);
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_kind_q   <= kind_i;
            req_heap_q   <= (request_size_i > SIZE_W'(MAX_CLASS_BYTES));
            req_cls_q    <= cls_in;
            req_idx_q    <= block_address_i[ADDR_W-1:2];
            cls_rd_vld_q <= cvld_q[cls_in];
            state_q      <= S_CLASS;
          end
        end
        S_CLASS, S_LINK: begin
          if (go_link) begin
            state_q <= S_LINK;
          end else if (finish) begin
            out_valid_q <= 1'b1;
            granted_q   <= res_granted;
            cls_out_q   <= res_heap ? '0 : req_cls_q;
            heap_q      <= res_heap;
            oop_q       <= res_oop;
            fc_out_q    <= res_fc;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign granted_address_o   = granted_q;
  assign size_class_o        = cls_out_q;
  assign to_heap_o           = heap_q;
  assign out_of_pages_o      = oop_q;
  assign class_free_blocks_o = fc_out_q;

endmodule
